FILE: design/tcw_pkg.sv
// shared types and character codes for the text console writer
package tcw_pkg;

    // one stored cell: attribute in the high byte, character in the low byte
    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] ch;
    } t_cell;

    // control flags from the cursor step logic
    typedef struct packed {
        logic store;
        logic scroll;
    } t_put_ctl;

    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_NUL = 8'h00;

endpackage

FILE: design/text_console_char_writer.sv
// text console engine: cell store, cursor and scroll sequencer
//
// Input channel (i_in_valid / o_in_ready) takes one request per beat: a put of
// i_char_code with i_attr_byte at the cursor, or a read of cell i_cell_index.
// Output channel (o_out_valid / i_out_ready) returns one result per request:
// the cursor after the request, the read cell (zero for puts) and a scroll flag.
// One request is in flight at a time; o_in_ready is low until its result beat
// has been taken, so a stalled receiver simply holds off the next request.
// A put that does not scroll goes from S_IDLE straight to S_OUT; a read
// passes through the RAM read register and S_RDWAIT, and a put that scrolls
// runs S_COPY and S_BLANK first. The scroll goes through the single memory
// port pair: the address counter copies one cell per cycle up by one row,
// then blanks the bottom row one cell per cycle.
// After reset the counter sweeps the whole store to zero with o_in_ready low;
// the cursor resets to home.
module text_console_char_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8,
    localparam int CW      = $clog2(COLUMNS),
    localparam int RW      = $clog2(ROWS),
    localparam int AW      = $clog2(COLUMNS * ROWS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_req_type,
    input  logic [7:0]    i_char_code,
    input  logic [7:0]    i_attr_byte,
    input  logic [AW-1:0] i_cell_index,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [CW-1:0] o_cursor_col,
    output logic [RW-1:0] o_cursor_row,
    output logic [7:0]    o_cell_char,
    output logic [7:0]    o_cell_attr,
    output logic          o_did_scroll
);

    localparam int CELLS = COLUMNS * ROWS;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_COPY   = 6'b000100,
        S_BLANK  = 6'b001000,
        S_RDWAIT = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [7:0]    r_blank_attr, n_blank_attr;
    logic          r_rd_ok, n_rd_ok;
    logic [7:0]    r_out_char, n_out_char;
    logic [7:0]    r_out_attr, n_out_attr;
    logic          r_scrolled, n_scrolled;

    logic          w_accept;
    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr;
    t_cell         w_wdata, w_rdata;
    logic [AW-1:0] w_put_addr;
    logic [CW-1:0] w_step_col;
    logic [RW-1:0] w_step_row;
    t_put_ctl      w_step_ctl;

    tcw_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tcw_cursor_step #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP),
        .CW       (CW),
        .RW       (RW)
    ) u_step (
        .i_col  (r_col),
        .i_row  (r_row),
        .i_char (i_char_code),
        .o_col  (w_step_col),
        .o_row  (w_step_row),
        .o_ctl  (w_step_ctl)
    );

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_put_addr = AW'(r_row * COLUMNS + r_col);

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_col        = r_col;
        n_row        = r_row;
        n_blank_attr = r_blank_attr;
        n_rd_ok      = r_rd_ok;
        n_out_char   = r_out_char;
        n_out_attr   = r_out_attr;
        n_scrolled   = r_scrolled;
        w_we         = 1'b0;
        w_waddr      = r_addr;
        w_wdata      = '0;
        w_re         = 1'b0;
        w_raddr      = i_cell_index;
        case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                if (r_addr == AW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req_type) begin
                        w_re       = 1'b1;
                        n_rd_ok    = ({1'b0, i_cell_index} < (AW + 1)'(CELLS));
                        n_scrolled = 1'b0;
                        n_state    = S_RDWAIT;
                    end else begin
                        n_col        = w_step_col;
                        n_row        = w_step_row;
                        n_out_char   = '0;
                        n_out_attr   = '0;
                        n_scrolled   = w_step_ctl.scroll;
                        n_blank_attr = i_attr_byte;
                        w_we         = w_step_ctl.store;
                        w_waddr      = w_put_addr;
                        w_wdata      = '{attr: i_attr_byte, ch: i_char_code};
                        if (w_step_ctl.scroll) begin
                            n_addr  = '0;
                            n_state = S_COPY;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                end
            end
            S_COPY: begin
                // read one row ahead, write the cell read in the previous cycle
                if (r_addr != AW'(CELLS - COLUMNS)) begin
                    w_re    = 1'b1;
                    w_raddr = r_addr + AW'(COLUMNS);
                end
                if (r_addr != '0) begin
                    w_we    = 1'b1;
                    w_waddr = r_addr - AW'(1);
                    w_wdata = w_rdata;
                end
                if (r_addr == AW'(CELLS - COLUMNS)) begin
                    n_state = S_BLANK;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_BLANK: begin
                w_we    = 1'b1;
                w_wdata = '{attr: r_blank_attr, ch: CH_NUL};
                if (r_addr == AW'(CELLS - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_RDWAIT: begin
                n_out_char = r_rd_ok ? w_rdata.ch : 8'h00;
                n_out_attr = r_rd_ok ? w_rdata.attr : 8'h00;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_addr  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blank_attr <= n_blank_attr;
        r_rd_ok      <= n_rd_ok;
        r_out_char   <= n_out_char;
        r_out_attr   <= n_out_attr;
        r_scrolled   <= n_scrolled;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_cursor_col = r_col;
    assign o_cursor_row = r_row;
    assign o_cell_char  = r_out_char;
    assign o_cell_attr  = r_out_attr;
    assign o_did_scroll = r_scrolled;

`ifndef SYNTHESIS
    // a scrolling put always leaves the cursor on the bottom row
    a_scroll_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_did_scroll |-> o_cursor_row == RW'(ROWS - 1))
        else $error("scroll result with cursor off the bottom row");

    // scrolling puts report an empty cell
    a_scroll_no_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_did_scroll |-> o_cell_char == 8'h00 && o_cell_attr == 8'h00)
        else $error("scroll result carries cell data");

    // cursor never leaves the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col} < (CW + 1)'(COLUMNS)) && ({1'b0, r_row} < (RW + 1)'(ROWS)))
        else $error("cursor outside the screen");

    // the store is only written while sweeping, while scrolling or on an accepted put
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_OUT || r_state == S_RDWAIT) && !w_accept
        |-> !w_we)
        else $error("store written without a request");
`endif

endmodule

FILE: design/tcw_cell_ram.sv
// cell store memory: one write port, one registered read port
module tcw_cell_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_cell         i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_cell         o_rdata
);

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/tcw_cursor_step.sv
// next cursor position for one put byte, with store and scroll flags
module tcw_cursor_step
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8,
    parameter int CW       = 7,
    parameter int RW       = 5
) (
    input  logic [CW-1:0] i_col,
    input  logic [RW-1:0] i_row,
    input  logic [7:0]    i_char,
    output logic [CW-1:0] o_col,
    output logic [RW-1:0] o_row,
    output t_put_ctl      o_ctl
);

    logic [CW-1:0] w_tab_col  [COLUMNS];
    logic          w_tab_wrap [COLUMNS];
    logic          w_row_up;

    // constant table: next tab stop per column, and whether it runs off the edge
    for (genvar c = 0; c < COLUMNS; c++) begin : g_tab
        localparam int NXT = (c / TAB_STOP + 1) * TAB_STOP;
        assign w_tab_wrap[c] = (NXT >= COLUMNS);
        assign w_tab_col[c]  = (NXT >= COLUMNS) ? '0 : CW'(NXT);
    end

    always_comb begin
        o_col       = i_col;
        o_row       = i_row;
        o_ctl.store = 1'b0;
        w_row_up    = 1'b0;
        case (i_char)
            CH_LF: begin
                o_col    = '0;
                w_row_up = 1'b1;
            end
            CH_TAB: begin
                o_col    = w_tab_col[i_col];
                w_row_up = w_tab_wrap[i_col];
            end
            CH_CR: begin
                o_col = '0;
            end
            CH_BS: begin
                if (i_col != '0) begin
                    o_col = i_col - CW'(1);
                end else if (i_row != '0) begin
                    o_col = CW'(COLUMNS - 1);
                    o_row = i_row - RW'(1);
                end
            end
            default: begin
                o_ctl.store = 1'b1;
                if (i_col == CW'(COLUMNS - 1)) begin
                    o_col    = '0;
                    w_row_up = 1'b1;
                end else begin
                    o_col = i_col + CW'(1);
                end
            end
        endcase
        o_ctl.scroll = 1'b0;
        if (w_row_up) begin
            if (i_row == RW'(ROWS - 1)) begin
                o_ctl.scroll = 1'b1;
            end else begin
                o_row = i_row + RW'(1);
            end
        end
    end

endmodule

FILE: bench/tb_top.sv
// self-checking bench for the text console writer: directed table, then random requests
`timescale 1ns / 100ps

module tb_top
    import tcw_pkg::*;
();

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;
    localparam int CELLS    = COLUMNS * ROWS;

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam int RANDOM_ITEMS = 508;
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int DRAIN_CYCLES = 2100;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 600;
    localparam int PLAN_ROWS    = 20;

    typedef struct packed {
        logic [6:0] col;
        logic [4:0] row;
        logic [7:0] ch;
        logic [7:0] attr;
        logic       scroll;
    } t_report;

    typedef struct packed {
        logic        req;
        logic [7:0]  ch;
        logic [7:0]  attr;
        logic [10:0] idx;
        logic [7:0]  reps;
        logic        typed;
        t_report     want;
    } t_stim;

    localparam t_report NO_REPORT = '0;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_req_type;
    logic [7:0]  i_char_code;
    logic [7:0]  i_attr_byte;
    logic [10:0] i_cell_index;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [6:0]  o_cursor_col;
    logic [4:0]  o_cursor_row;
    logic [7:0]  o_cell_char;
    logic [7:0]  o_cell_attr;
    logic        o_did_scroll;

    text_console_char_writer u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_char_code  (i_char_code),
        .i_attr_byte  (i_attr_byte),
        .i_cell_index (i_cell_index),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr),
        .o_did_scroll (o_did_scroll)
    );

    // shadow copy of the screen and cursor
    t_cell   screen [CELLS];
    int      cur_col;
    int      cur_row;

    t_report report_q [$];
    int      mismatches;
    int      reports_checked;
    int      burst_left;
    int      cycles;
    t_stim   plan [PLAN_ROWS];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // applies one request to the shadow console and returns the cursor report
    function automatic t_report advance_console(logic req, logic [7:0] ch, logic [7:0] attr,
                                                logic [10:0] idx);
        t_report r;
        int      col;
        int      row;
        r   = '0;
        col = cur_col;
        row = cur_row;
        if (req == REQ_READ) begin
            if (idx < CELLS) begin
                r.ch   = screen[idx].ch;
                r.attr = screen[idx].attr;
            end
        end else begin
            case (ch)
                CH_LF: begin
                    col = 0;
                    row++;
                end
                CH_TAB: col = col + TAB_STOP - (col % TAB_STOP);
                CH_CR:  col = 0;
                CH_BS: begin
                    if (col > 0) begin
                        col--;
                    end else if (row > 0) begin
                        row--;
                        col = COLUMNS - 1;
                    end
                end
                default: begin
                    screen[row * COLUMNS + col] = '{attr: attr, ch: ch};
                    col++;
                end
            endcase
            if (col >= COLUMNS) begin
                col = 0;
                row++;
            end
            if (row > ROWS - 1) begin
                for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
                for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = '{attr: attr, ch: CH_NUL};
                row      = ROWS - 1;
                r.scroll = 1'b1;
            end
        end
        cur_col = col;
        cur_row = row;
        r.col   = col[6:0];
        r.row   = row[4:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        mismatches++;
    endtask

    // offers one beat, records its expected report on acceptance, then maybe idles
    task automatic send_request(logic req, logic [7:0] ch, logic [7:0] attr, logic [10:0] idx,
                                logic typed, t_report want);
        t_report predicted;
        int      gap;
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_req_type   = req;
        i_char_code  = ch;
        i_attr_byte  = attr;
        i_cell_index = idx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = advance_console(req, ch, attr, idx);
        report_q.push_back(typed ? want : predicted);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(40, 80);
                gap = 0;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(0, 8);
            end
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // result beats against the oldest expectation
    initial begin
        t_report want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (report_q.size() == 0) begin
                    report_mismatch("result beat with nothing pending", 1, 0);
                end else begin
                    want = report_q.pop_front();
                    if (o_cursor_col !== want.col)
                        report_mismatch("cursor_col", o_cursor_col, want.col);
                    if (o_cursor_row !== want.row)
                        report_mismatch("cursor_row", o_cursor_row, want.row);
                    if (o_cell_char !== want.ch)
                        report_mismatch("cell_char", o_cell_char, want.ch);
                    if (o_cell_attr !== want.attr)
                        report_mismatch("cell_attr", o_cell_attr, want.attr);
                    if (o_did_scroll !== want.scroll)
                        report_mismatch("did_scroll", o_did_scroll, want.scroll);
                end
                reports_checked++;
            end
        end
    end

    // receiver: rotating stall mask plus one long hold-off
    initial begin
        int         phase;
        logic [7:0] mask;
        bit         held;
        i_out_ready = 1'b0;
        phase = 0;
        mask  = 8'hFF;
        held  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && reports_checked >= HOLD_AFTER) begin
                held = 1'b1;
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (phase % 64 == 0)
                mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
            i_out_ready = mask[phase % 8];
            phase++;
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) @(posedge i_clk) cycles++;
        $display("text_console_char_writer test failed");
        $finish;
    end

    initial begin
        t_stim       step_row;
        int          pick;
        int          sub;
        logic        req;
        logic [7:0]  ch;
        logic [7:0]  attr;
        logic [10:0] idx;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_req_type   = REQ_PUT;
        i_char_code  = CH_NUL;
        i_attr_byte  = 8'h00;
        i_cell_index = '0;
        mismatches      = 0;
        reports_checked = 0;
        burst_left      = 0;
        cur_col = 0;
        cur_row = 0;
        for (int i = 0; i < CELLS; i++) screen[i] = '0;

        plan = '{
            // fresh screen reads back zero, in range and past the end
            '{REQ_READ, CH_NUL, 8'h00, 11'd0,    8'd1, 1'b1, '{7'd0, 5'd0, 8'h00, 8'h00, 1'b0}},
            '{REQ_READ, CH_NUL, 8'h00, 11'd1999, 8'd1, 1'b1, '{7'd0, 5'd0, 8'h00, 8'h00, 1'b0}},
            '{REQ_READ, CH_NUL, 8'h00, 11'd2047, 8'd1, 1'b1, '{7'd0, 5'd0, 8'h00, 8'h00, 1'b0}},
            // backspace at home stays put
            '{REQ_PUT,  CH_BS,  8'h5A, 11'd0,    8'd1, 1'b1, '{7'd0, 5'd0, 8'h00, 8'h00, 1'b0}},
            '{REQ_PUT,  8'h41,  8'hFF, 11'd0,    8'd1, 1'b1, '{7'd1, 5'd0, 8'h00, 8'h00, 1'b0}},
            '{REQ_PUT,  8'hFF,  8'h00, 11'd0,    8'd1, 1'b1, '{7'd2, 5'd0, 8'h00, 8'h00, 1'b0}},
            '{REQ_PUT,  CH_NUL, 8'hFF, 11'd0,    8'd1, 1'b1, '{7'd3, 5'd0, 8'h00, 8'h00, 1'b0}},
            '{REQ_READ, CH_NUL, 8'h00, 11'd0,    8'd1, 1'b1, '{7'd3, 5'd0, 8'h41, 8'hFF, 1'b0}},
            '{REQ_READ, CH_NUL, 8'h00, 11'd1,    8'd1, 1'b1, '{7'd3, 5'd0, 8'hFF, 8'h00, 1'b0}},
            '{REQ_READ, CH_NUL, 8'h00, 11'd2,    8'd1, 1'b1, '{7'd3, 5'd0, 8'h00, 8'hFF, 1'b0}},
            '{REQ_PUT,  CH_CR,  8'h00, 11'd0,    8'd1, 1'b1, '{7'd0, 5'd0, 8'h00, 8'h00, 1'b0}},
            '{REQ_PUT,  CH_TAB, 8'h00, 11'd0,    8'd1, 1'b1, '{7'd8, 5'd0, 8'h00, 8'h00, 1'b0}},
            '{REQ_PUT,  CH_BS,  8'h00, 11'd0,    8'd1, 1'b1, '{7'd7, 5'd0, 8'h00, 8'h00, 1'b0}},
            '{REQ_PUT,  CH_LF,  8'h00, 11'd0,    8'd1, 1'b1, '{7'd0, 5'd1, 8'h00, 8'h00, 1'b0}},
            // backspace wraps to the end of the row above
            '{REQ_PUT,  CH_BS,  8'h00, 11'd0,    8'd1, 1'b1, '{7'd79, 5'd0, 8'h00, 8'h00, 1'b0}},
            // tab from the last column wraps to the next row
            '{REQ_PUT,  CH_TAB, 8'h00, 11'd0,    8'd1, 1'b1, '{7'd0, 5'd1, 8'h00, 8'h00, 1'b0}},
            '{REQ_PUT,  CH_LF,  8'h11, 11'd0,    8'd23, 1'b0, NO_REPORT},
            // newline on the bottom row scrolls and blanks with its attribute
            '{REQ_PUT,  CH_LF,  8'hA5, 11'd0,    8'd1, 1'b1, '{7'd0, 5'd24, 8'h00, 8'h00, 1'b1}},
            '{REQ_READ, CH_NUL, 8'h00, 11'd1920, 8'd1, 1'b1, '{7'd0, 5'd24, 8'h00, 8'hA5, 1'b0}},
            '{REQ_READ, CH_NUL, 8'h00, 11'd0,    8'd1, 1'b0, NO_REPORT}
        };

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int k = 0; k < PLAN_ROWS; k++) begin
            step_row = plan[k];
            repeat (step_row.reps)
                send_request(step_row.req, step_row.ch, step_row.attr, step_row.idx,
                             step_row.typed, step_row.want);
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            sub  = $urandom_range(0, 99);
            ch   = 8'($urandom_range(0, 255));
            attr = 8'($urandom_range(0, 255));
            idx  = 11'($urandom_range(0, 2047));
            if (pick < 30) begin
                req = REQ_READ;
                // two in five reads pick a cell on the cursor row, where recent text lives
                if (sub < 40)
                    idx = 11'(cur_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
                else if (sub < 90)
                    idx = 11'($urandom_range(0, CELLS - 1));
                else
                    idx = 11'($urandom_range(CELLS, 2047));
            end else begin
                req = REQ_PUT;
                if (sub >= 94)      ch = CH_BS;
                else if (sub >= 89) ch = CH_TAB;
                else if (sub >= 85) ch = CH_CR;
                else if (sub >= 80) ch = CH_LF;
            end
            send_request(req, ch, attr, idx, 1'b0, NO_REPORT);
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;

        while (report_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && report_q.size() == 0) begin
            $display("text_console_char_writer test passed");
        end else begin
            $display("text_console_char_writer test failed");
        end
        $finish;
    end

endmodule
